### rtl/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, field packing and the types shared by the cell row and the top level.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int CFG_W       = 4;
  localparam int COUNT_W     = 32;
  localparam int IDX_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  localparam int IN_TDATA_W  = ((PAGE_BITS + 7) / 8) * 8;
  localparam int OUT_W       = 2 + PAGE_BITS + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(8);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  typedef logic [PAGE_BITS-1:0] page_t;

  // What one cell hands to the next one down the row.
  typedef struct packed {
    page_t page;
    logic  valid;
    logic  pass;
  } link_t;

  // Broadcast to every cell for the beat being taken.
  typedef struct packed {
    page_t page;
    logic  hit;
    logic  evict;
    logic  en;
  } cell_ctl_t;

endpackage

### rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement frame store
// Fully associative recency stack built as a row of cells; reports faults,
// evictions and a saturating fault total for every page reference.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         page reference
//  m_axis    out        fault, evicted_valid, evicted_page, fault_total
//  cfg       in         frames_in_use (write only)
//
//  One reference is taken per cycle unless the output stalls; the compare and
//  the shift through the cell row finish in the cycle the beat is accepted.
//  The result appears in the output register in the cycle after acceptance.
//  A stalled output holds s_axis_tready low until the result is taken; the
//  output register can be refilled in the cycle it is drained.
//  Reset empties the stack, clears the fault total and sets frames_in_use to 8.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] page
  input  logic [lrupr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] fault, [1] evicted_valid, [17:2] evicted_page, [49:18] fault_total
  output logic [lrupr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]          cfg_wr_data
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0]      frames_in_use;
  logic [COUNT_W-1:0]    fault_count;
  logic [COUNT_W-1:0]    fault_count_next;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                  out_valid;

  logic                  accept;
  page_t                 in_page;
  logic                  hit;
  logic                  evict;
  logic [IDX_W-1:0]      lim_idx;
  page_t                 ev_page;
  cell_ctl_t             ctl;

  link_t                 links [0:MAX_FRAMES];
  logic [MAX_FRAMES-1:0] match_vec;
  logic [MAX_FRAMES-1:0] valid_vec;
  page_t                 ev_pages [0:MAX_FRAMES-1];
  logic [OUT_W-1:0]      out_word;

  assign in_page       = s_axis_tdata[PAGE_BITS-1:0];
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign links[0].page  = in_page;
  assign links[0].valid = 1'b1;
  assign links[0].pass  = 1'b1;

  assign ctl.page  = in_page;
  assign ctl.hit   = hit;
  assign ctl.evict = evict;
  assign ctl.en    = accept;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic down_valid;
    if (i == MAX_FRAMES - 1) begin : g_tail
      assign down_valid = 1'b0;
    end else begin : g_body
      assign down_valid = valid_vec[i+1];
    end

    lrupr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .up         (links[i]),
      .down_valid (down_valid),
      .dn         (links[i+1]),
      .match      (match_vec[i]),
      .valid_q    (valid_vec[i]),
      .evict_page (ev_pages[i])
    );
  end

  // Zero frames act as one; anything past the stack depth acts as the full depth.
  always_comb begin
    if (frames_in_use == '0) begin
      lim_idx = '0;
    end else if (int'(frames_in_use) > MAX_FRAMES) begin
      lim_idx = IDX_W'(MAX_FRAMES - 1);
    end else begin
      lim_idx = IDX_W'(frames_in_use - CFG_W'(1));
    end
  end

  // Valid slots always form a run from the top, so the slot at the limit
  // tells whether the store is full.
  assign hit   = |match_vec;
  assign evict = !hit && valid_vec[lim_idx];

  always_comb begin
    ev_page = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      ev_page = ev_page | ev_pages[i];
    end
  end

  always_comb begin
    fault_count_next = fault_count;
    if (!hit && (fault_count != COUNT_MAX)) begin
      fault_count_next = fault_count + COUNT_W'(1);
    end
  end

  assign out_word = {fault_count_next, ev_page, evict, !hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_count <= '0;
    end else if (accept) begin
      fault_count <= fault_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= OUT_TDATA_W'(out_word);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // The resident pages always occupy a run of slots starting at the top.
  a_valid_run: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + MAX_FRAMES'(1))) == '0)
    else $error("resident slots are not contiguous from the top");

  // After any accepted reference the top slot holds a resident page.
  a_top_filled: assert property (@(posedge clk) disable iff (rst)
    accept |=> valid_vec[0])
    else $error("top slot empty after a reference");

  // A hit leaves the fault total unchanged.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (accept && hit) |=> (fault_count == $past(fault_count)))
    else $error("fault total moved on a hit");

  // An eviction is only ever reported together with a fault.
  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[1]) |-> out_data[0])
    else $error("eviction reported without a fault");

endmodule

### rtl/lrupr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU stack cell
// Holds one slot of the recency stack, compares it against the reference and
// takes its upper neighbor's slot when the shift wave reaches it.
// ----------------------------------------------------------------------------
module lrupr_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lrupr_pkg::cell_ctl_t ctl,
  input  lrupr_pkg::link_t     up,
  input  logic                 down_valid,
  output lrupr_pkg::link_t     dn,
  output logic                 match,
  output logic                 valid_q,
  output lrupr_pkg::page_t     evict_page
);
  import lrupr_pkg::*;

  page_t page_q;
  logic  last;
  logic  stop;

  assign match = valid_q && (page_q == ctl.page);
  assign last  = valid_q && !down_valid;

  // The shift wave ends at the hit slot, at the slot being evicted, or at the
  // first free slot on a miss that leaves room.
  assign stop = (ctl.hit && match) ||
                (!ctl.hit && ctl.evict && last) ||
                (!ctl.hit && !valid_q);

  assign dn.page  = page_q;
  assign dn.valid = valid_q;
  assign dn.pass  = up.pass && !stop;

  assign evict_page = (ctl.evict && last) ? page_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.en && up.pass) begin
      valid_q <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && up.pass) begin
      page_q <= up.page;
    end
  end

endmodule

### verif/lru_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement result checker
// Watches the page reference, result and frame limit channels, keeps its own
// recency stack and fault total, and compares every result beat field by field
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module lru_result_checker
  import lrupr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // [15:0] page
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] fault, [1] evicted_valid, [17:2] evicted_page, [49:18] fault_total
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  output int                     fail_count,
  output logic                   busy
);

  // Member order puts the fault flag in bit 0, matching the result beat.
  typedef struct packed {
    logic [COUNT_W-1:0] total;
    page_t              ev_page;
    logic               ev_valid;
    logic               fault;
  } lru_result_t;

  page_t              res_page  [MAX_FRAMES];
  logic               res_valid [MAX_FRAMES];
  logic [COUNT_W-1:0] faults;
  logic [CFG_W-1:0]   frame_limit;
  lru_result_t        expected_q [$];

  task automatic flag(input string what, input longint unsigned want,
                      input longint unsigned got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
               $realtime, what, want, got);
  endtask

  // Looks the page up in the recency stack, updates the stack and the fault
  // total, and returns the result the block should report.
  function automatic lru_result_t lookup_page(input page_t pg);
    lru_result_t r;
    int          n_valid;
    int          hit_at;
    int          lim;
    int          shift_top;
    bit          hit;
    r = '0;
    n_valid = 0;
    hit_at = 0;
    hit = 1'b0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (res_valid[i]) begin
        n_valid = i + 1;
        if (!hit && res_page[i] == pg) begin
          hit = 1'b1;
          hit_at = i;
        end
      end
    end
    lim = int'(frame_limit);
    if (lim < 1) lim = 1;
    if (lim > MAX_FRAMES) lim = MAX_FRAMES;
    if (hit) begin
      shift_top = hit_at;
    end else begin
      r.fault = 1'b1;
      if (faults != COUNT_MAX) faults++;
      // A lowered limit never flushes; a full stack just keeps evicting.
      if (n_valid >= lim) begin
        r.ev_valid = 1'b1;
        r.ev_page = res_page[n_valid-1];
        shift_top = n_valid - 1;
      end else begin
        shift_top = n_valid;
      end
    end
    for (int i = shift_top; i > 0; i--) begin
      res_page[i] = res_page[i-1];
      res_valid[i] = res_valid[i-1];
    end
    res_page[0] = pg;
    res_valid[0] = 1'b1;
    r.total = faults;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lru_result_t got;
    lru_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        res_page[i] = '0;
        res_valid[i] = 1'b0;
      end
      faults = '0;
      frame_limit = FRAMES_RESET;
      expected_q.delete();
      fail_count = 0;
      busy <= 1'b0;
    end else begin
      // Retire before predicting so a stray beat cannot consume a new entry.
      if (m_axis_tvalid && m_axis_tready) begin
        got = lru_result_t'(m_axis_tdata[OUT_W-1:0]);
        if (expected_q.size() == 0) begin
          flag("result beat with no reference pending", 0, m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got.fault !== want.fault) flag("fault", want.fault, got.fault);
          if (got.ev_valid !== want.ev_valid)
            flag("evicted_valid", want.ev_valid, got.ev_valid);
          if (got.ev_page !== want.ev_page) flag("evicted_page", want.ev_page, got.ev_page);
          if (got.total !== want.total) flag("fault_total", want.total, got.total);
        end
      end
      if (cfg_wr_en) frame_limit = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(lookup_page(s_axis_tdata[PAGE_BITS-1:0]));
      busy <= (expected_q.size() != 0);
    end
  end

endmodule

### verif/tb_lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives directed and random page reference streams under several frame
// limits, with random gaps and back-pressure, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  int   fail_count;
  logic busy;
  int   cycle_count = 0;
  bit   tx_gaps = 1'b1;
  bit   rx_stalls = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_page_replacement DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  lru_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .busy          (busy)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rx_stalls || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Valid stays high from one beat to the next unless a gap is taken.
  task automatic send_page(input page_t pg);
    while (tx_gaps && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'(pg);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_frames(input logic [CFG_W-1:0] limit);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Most references come from a small working set so hits are frequent.
  task automatic run_random(input int n_items);
    page_t pool [16];
    int    pool_n;
    int    pick;
    page_t pg;
    pool_n = $urandom_range(14, 3);
    for (int i = 0; i < pool_n; i++) pool[i] = page_t'($urandom);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pg = pool[$urandom_range(pool_n - 1)];
      end else if (pick < 90) begin
        pg = page_t'($urandom);
      end else begin
        case ($urandom_range(2))
          0: pg = '0;
          1: pg = '1;
          default: pg = page_t'(1) << $urandom_range(PAGE_BITS - 1);
        endcase
      end
      send_page(pg);
    end
  endtask

  initial begin : stimulus
    int frames_plan [11];
    frames_plan = '{8, 1, 4, 0, 15, 2, 9, 5, 7, 3, 6};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A zero limit acts as one frame: the second miss already evicts.
    set_frames(4'd0);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hFFFF);

    set_frames(4'd2);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0001);

    // Limit above the stack depth saturates; fill up and hit the deepest slot.
    set_frames(4'd15);
    for (int p = 3; p <= 8; p++) send_page(page_t'(p));
    send_page(16'h0002);
    send_page(16'h8000);

    // Lowering the limit on a full stack keeps resident pages hittable.
    set_frames(4'd3);
    send_page(16'h0005);
    send_page(16'h7FFF);

    for (int ph = 0; ph < 11; ph++) begin
      tx_gaps = !(ph == 4 || ph == 5);
      rx_stalls = !(ph == 4 || ph == 5);
      set_frames(frames_plan[ph][CFG_W-1:0]);
      run_random(55);
    end

    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### lru_page_replacement.f
rtl/lrupr_pkg.sv
rtl/lrupr_cell.sv
rtl/lru_page_replacement.sv
verif/lru_result_checker.sv
verif/tb_lru_page_replacement.sv
